// File: rtl/core/mfi_pkg.sv
// ----------------------------------------------------------------------------
// mfi_pkg
// Shared constants and types for the money flow index core.
// ----------------------------------------------------------------------------
package mfi_pkg;

    localparam int MAX_PERIOD_DEF  = 32;
    localparam int PRICE_BITS_DEF  = 24;
    localparam int VOLUME_BITS_DEF = 32;

    localparam int PERIOD_W   = 6;
    localparam int MFI_W      = 15;
    localparam int FLOW_W     = 58;
    localparam int SUM_W      = 63;
    localparam int TOTAL_W    = 64;
    localparam int PERIOD_RST = 14;
    localparam int MFI_FULL   = 25600;
    // 25600 * pos fits in 63 + 15 bits
    localparam int NUM_W      = SUM_W + MFI_W;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  pos;
        logic [TOTAL_W-1:0] total;
    } div_req_t;

endpackage

// File: rtl/core/money_flow_index_core.sv
// ----------------------------------------------------------------------------
// money_flow_index_core
// Money flow index over a sliding window of bar flows held in a ring memory.
// Each bar passes READ then OUT if it is the first of a series, else READ, UPD,
// DIV and OUT, waiting in DIV while a full window runs the 78-step divider.
// A new bar is accepted only in IDLE once the last result word has been taken.
// Reset: period returns to 14 and the history clears; the ring is not cleared.
// ----------------------------------------------------------------------------
module money_flow_index_core
#(
    parameter int MAX_PERIOD  = mfi_pkg::MAX_PERIOD_DEF,
    parameter int PRICE_BITS  = mfi_pkg::PRICE_BITS_DEF,
    parameter int VOLUME_BITS = mfi_pkg::VOLUME_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mfi_pkg::PERIOD_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PRICE_BITS-1:0]         high_price,
    input  logic [PRICE_BITS-1:0]         low_price,
    input  logic [PRICE_BITS-1:0]         close_price,
    input  logic [VOLUME_BITS-1:0]        volume,
    input  logic                          start_series,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mfi_pkg::MFI_W-1:0]     mfi_value,
    output logic                          mfi_valid,
    output logic                          is_up,
    output logic [mfi_pkg::FLOW_W-1:0]    raw_flow
);
    import mfi_pkg::*;

    localparam int PTR_W  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
    localparam int PSUM_W = PRICE_BITS + 2;
    localparam int PER_W  = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PSUM_W-1:0]   prev_reg;
    logic                have_prev_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    pos_reg, neg_reg;
    logic [FLOW_W-1:0]   flow_reg;
    logic                up_reg, first_reg;
    logic [MFI_W-1:0]    mfi_reg;
    logic                mvalid_reg;

    // ring memory: flow plus up bit
    logic [FLOW_W:0]     ring_mem [MAX_PERIOD];
    logic [FLOW_W:0]     ring_rd_reg;

    logic [PER_W-1:0]    n_act;
    logic [CNT_W-1:0]    n_cnt;
    logic [PSUM_W-1:0]   s_in;
    logic [SUM_W-1:0]    pos_sub, neg_sub, pos_new, neg_new;
    logic                full_old;
    logic                full_after;
    logic [PTR_W-1:0]    ptr_use;
    div_req_t            dreq;
    logic                div_busy, div_done;
    logic [MFI_W-1:0]    div_q;

    always_comb
    begin
        if (period_reg < PERIOD_W'(2))
            n_act = PER_W'(2);
        else if (PER_W'(period_reg) > PER_W'(MAX_PERIOD))
            n_act = PER_W'(MAX_PERIOD);
        else
            n_act = PER_W'(period_reg);
    end
    assign n_cnt = CNT_W'(n_act);

    assign s_in = PSUM_W'(high_price) + PSUM_W'(low_price) + PSUM_W'(close_price);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid;

    // wrap pointer when the period has shrunk
    assign ptr_use  = (CNT_W'(ptr_reg) >= n_cnt) ? '0 : ptr_reg;
    assign full_old = count_reg >= n_cnt;
    assign full_after = full_old || ((count_reg + 1'b1) >= n_cnt);

    always_comb
    begin
        pos_sub = pos_reg;
        neg_sub = neg_reg;
        if (full_old)
        begin
            if (ring_rd_reg[FLOW_W])
                pos_sub = pos_reg - SUM_W'(ring_rd_reg[FLOW_W-1:0]);
            else
                neg_sub = neg_reg - SUM_W'(ring_rd_reg[FLOW_W-1:0]);
        end
        pos_new = up_reg ? pos_sub + SUM_W'(flow_reg) : pos_sub;
        neg_new = up_reg ? neg_sub : neg_sub + SUM_W'(flow_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid && in_ready) state_next = ST_READ;
            ST_READ: state_next = first_reg ? ST_OUT : ST_UPD;
            ST_UPD:  state_next = ST_DIV;
            // hold until the divider, if started, has finished
            ST_DIV:  if (!div_busy) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign dreq.start = (state_reg == ST_UPD) && full_after && (neg_new != '0);
    assign dreq.pos   = pos_new;
    assign dreq.total = TOTAL_W'(pos_new) + TOTAL_W'(neg_new);

    mfi_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            ring_rd_reg <= ring_mem[ptr_use];
        if (state_reg == ST_UPD)
            ring_mem[ptr_use] <= {up_reg, flow_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            period_reg    <= PERIOD_W'(PERIOD_RST);
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            neg_reg       <= '0;
            out_valid     <= 1'b0;
            mvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                period_reg    <= cfg_wdata;
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                ptr_reg       <= '0;
                count_reg     <= '0;
                pos_reg       <= '0;
                neg_reg       <= '0;
            end
            else if (state_reg == ST_IDLE && in_valid && in_ready)
            begin
                prev_reg      <= s_in;
                have_prev_reg <= 1'b1;
                if (start_series)
                begin
                    ptr_reg   <= '0;
                    count_reg <= '0;
                    pos_reg   <= '0;
                    neg_reg   <= '0;
                end
            end
            else if (state_reg == ST_UPD)
            begin
                pos_reg    <= pos_new;
                neg_reg    <= neg_new;
                mvalid_reg <= full_after;
                if (!full_old)
                    count_reg <= count_reg + 1'b1;
                ptr_reg <= (CNT_W'(ptr_use) + 1'b1 >= n_cnt) ? '0 : ptr_use + 1'b1;
            end
            else if (state_reg == ST_READ && first_reg)
                mvalid_reg <= 1'b0;
            if (state_reg == ST_OUT)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            up_reg    <= have_prev_reg && !start_series && (s_in > prev_reg);
            first_reg <= !have_prev_reg || start_series;
            flow_reg  <= FLOW_W'(s_in) * FLOW_W'(volume);
        end
        if (state_reg == ST_UPD)
            mfi_reg <= MFI_W'(MFI_FULL);
        else if (div_done)
            mfi_reg <= div_q;
    end

    assign mfi_value = mvalid_reg ? mfi_reg : '0;
    assign mfi_valid = mvalid_reg;
    assign is_up     = up_reg;
    assign raw_flow  = first_reg ? '0 : flow_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("word accepted while busy");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PERIOD))
        else $error("flow count overrun");
    a_first_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && first_reg) |-> (!mfi_valid && !is_up))
        else $error("first bar reported a flow");

endmodule

// File: rtl/core/mfi_div.sv
// ----------------------------------------------------------------------------
// mfi_div
// Restoring divider, one quotient bit per cycle:
// q = floor((25600*pos + floor(total/2)) / total).
// ----------------------------------------------------------------------------
module mfi_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mfi_pkg::div_req_t            req,
    output logic                         busy,
    output logic                         done,
    output logic [mfi_pkg::MFI_W-1:0]    quot
);
    import mfi_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   num_reg, num_next;
    logic [TOTAL_W:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0] den_reg, den_next;
    logic [MFI_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   shifted;
    logic [NUM_W-1:0]   prod;

    // 25600 = 2^10 * 25 = 2^10 * (16 + 8 + 1)
    assign prod = ({{MFI_W{1'b0}}, req.pos} << 14) + ({{MFI_W{1'b0}}, req.pos} << 13)
                + ({{MFI_W{1'b0}}, req.pos} << 10)
                + {{(NUM_W-TOTAL_W+1){1'b0}}, req.total[TOTAL_W-1:1]};

    assign shifted = {rem_reg[TOTAL_W-1:0], num_reg[NUM_W-1]};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = prod;
            rem_next  = '0;
            den_next  = req.total;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[MFI_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[MFI_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("divider done held");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !req.start)
        else $error("divider restarted while busy");
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quot <= MFI_W'(MFI_FULL))
        else $error("index above full scale");

endmodule

// File: verif/money_flow_index_core_test.sv
// ----------------------------------------------------------------------------
// money_flow_index_core_test
// Drives price bars through the core in random bursts while the output side
// stalls on its own pattern, predicts each result word in the bench and
// compares every field. Covers several period settings, series restarts and
// the extremes of prices and volume.
// ----------------------------------------------------------------------------
module money_flow_index_core_test;

    import mfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [23:0] hi;
        logic [23:0] lo;
        logic [23:0] cl;
        logic [31:0] vol;
        logic        start;
    } bar_t;

    typedef struct packed {
        logic [MFI_W-1:0]  mfi;
        logic              valid;
        logic              up;
        logic [FLOW_W-1:0] flow;
    } mfi_word_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic [23:0]         high_price;
    logic [23:0]         low_price;
    logic [23:0]         close_price;
    logic [31:0]         volume;
    logic                start_series;
    logic                out_valid;
    logic                out_ready;
    logic [MFI_W-1:0]    mfi_value;
    logic                mfi_valid;
    logic                is_up;
    logic [FLOW_W-1:0]   raw_flow;

    bar_t      pending_bars[$];
    mfi_word_t expected_words[$];
    int        error_count;
    int        words_seen;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    logic      hold_off;

    // predictor state
    int unsigned       pred_period;
    logic [25:0]       prev_sum;
    logic              have_prev;
    logic [FLOW_W-1:0] ring_flow[MAX_PERIOD_DEF];
    logic              ring_up[MAX_PERIOD_DEF];
    int unsigned       ring_ptr;
    int unsigned       flow_cnt;
    logic [SUM_W-1:0]  pos_sum;
    logic [SUM_W-1:0]  neg_sum;

    money_flow_index_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .high_price   (high_price),
        .low_price    (low_price),
        .close_price  (close_price),
        .volume       (volume),
        .start_series (start_series),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mfi_value    (mfi_value),
        .mfi_valid    (mfi_valid),
        .is_up        (is_up),
        .raw_flow     (raw_flow)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void clear_history();
        prev_sum  = '0;
        have_prev = 1'b0;
        ring_ptr  = 0;
        flow_cnt  = 0;
        pos_sum   = '0;
        neg_sum   = '0;
    endfunction

    function automatic mfi_word_t predict_mfi(bar_t b);
        mfi_word_t   w;
        logic [25:0] s;
        int unsigned n;
        logic [127:0] num;
        logic [127:0] total;
        w = '0;
        s = 26'(b.hi) + 26'(b.lo) + 26'(b.cl);
        n = (pred_period < 2) ? 2 : ((pred_period > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF
                                                                   : pred_period);
        if (b.start)
            clear_history();
        if (have_prev)
        begin
            w.up   = s > prev_sum;
            w.flow = FLOW_W'(s) * FLOW_W'(b.vol);
            if (ring_ptr >= n)
                ring_ptr = 0;
            if (flow_cnt >= n)
            begin
                // drop the word leaving the window
                if (ring_up[ring_ptr])
                    pos_sum = pos_sum - SUM_W'(ring_flow[ring_ptr]);
                else
                    neg_sum = neg_sum - SUM_W'(ring_flow[ring_ptr]);
            end
            else
                flow_cnt++;
            ring_flow[ring_ptr] = w.flow;
            ring_up[ring_ptr]   = w.up;
            if (w.up)
                pos_sum = pos_sum + SUM_W'(w.flow);
            else
                neg_sum = neg_sum + SUM_W'(w.flow);
            ring_ptr = (ring_ptr + 1 >= n) ? 0 : ring_ptr + 1;
            if (flow_cnt >= n)
            begin
                w.valid = 1'b1;
                if (neg_sum == 0)
                    w.mfi = MFI_W'(MFI_FULL);
                else
                begin
                    total = 128'(pos_sum) + 128'(neg_sum);
                    num   = 128'(pos_sum) * 128'(MFI_FULL) + (total >> 1);
                    w.mfi = MFI_W'(num / total);
                end
            end
        end
        prev_sum  = s;
        have_prev = 1'b1;
        return w;
    endfunction

    // driver: bursts with random gaps, paused on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            high_price   <= '0;
            low_price    <= '0;
            close_price  <= '0;
            volume       <= '0;
            start_series <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_words.push_back(predict_mfi({high_price, low_price, close_price,
                                                      volume, start_series}));
            if (gap_left > 0 || hold_off || pending_bars.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                bar_t b;
                b = pending_bars.pop_front();
                in_valid     <= 1'b1;
                high_price   <= b.hi;
                low_price    <= b.lo;
                close_price  <= b.cl;
                volume       <= b.vol;
                start_series <= b.start;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            words_seen  <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            out_ready <= (words_seen[8]) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else
                begin
                    mfi_word_t e;
                    e = expected_words.pop_front();
                    if (mfi_value !== e.mfi)
                    begin
                        $error("mfi_value expected %0d got %0d", e.mfi, mfi_value);
                        error_count++;
                    end
                    if (mfi_valid !== e.valid)
                    begin
                        $error("mfi_valid expected %0d got %0d", e.valid, mfi_valid);
                        error_count++;
                    end
                    if (is_up !== e.up)
                    begin
                        $error("is_up expected %0d got %0d", e.up, is_up);
                        error_count++;
                    end
                    if (raw_flow !== e.flow)
                    begin
                        $error("raw_flow expected %0d got %0d", e.flow, raw_flow);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d words outstanding", expected_words.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bar_t random_bar(logic [25:0] trend);
        bar_t b;
        int   mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            b.hi = 24'($urandom);
            b.lo = 24'($urandom);
            b.cl = 24'($urandom);
        end
        else
        begin
            // walk around a base so up and down bars both occur
            b.hi = 24'(trend + $urandom_range(0, 4000));
            b.lo = 24'(trend - $urandom_range(0, 4000));
            b.cl = 24'(trend + $urandom_range(0, 4000) - 2000);
        end
        case ($urandom_range(0, 4))
            0: b.vol = $urandom_range(0, 3);
            1: b.vol = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: b.vol = $urandom;
        endcase
        b.start = ($urandom_range(0, 150) == 0);
        return b;
    endfunction

    task automatic wait_idle();
        while (pending_bars.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= PERIOD_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        pred_period = value;
        clear_history();
    endtask

    initial
    begin
        logic [25:0] base;
        int unsigned periods[6];
        error_count  = 0;
        hold_off     = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        rst_n        = 1'b0;
        pred_period  = PERIOD_RST;
        clear_history();
        periods = '{2, 32, 0, 63, 5, 14};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, flat and rising bars, restart mid series
        pending_bars.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0});
        pending_bars.push_back('{24'h0, 24'h0, 24'h0, 32'h0, 1'b0});
        pending_bars.push_back('{24'h0, 24'h0, 24'h0, 32'hFFFFFFFF, 1'b0});
        for (int i = 0; i < 16; i++)
            pending_bars.push_back('{24'(100 + i), 24'(50 + i), 24'(70 + i),
                                     32'(1000 * i), 1'b0});
        pending_bars.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1});
        pending_bars.push_back('{24'h1, 24'h0, 24'h0, 32'h7, 1'b0});
        pending_bars.push_back('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0});
        wait_idle();

        foreach (periods[p])
        begin
            write_period(periods[p]);
            base = 26'($urandom_range(10000, 24'hFF0000));
            for (int i = 0; i < 340; i++)
            begin
                base = base + 26'($urandom_range(0, 600)) - 26'(300);
                if (base > 26'hFF0000 || base < 26'd10000)
                    base = 26'd8000000;
                pending_bars.push_back(random_bar(base));
            end
            // pause the sender mid stream until the core drains, then resume
            if (p == 1)
            begin
                while (pending_bars.size() > 170)
                    @(posedge clk);
                hold_off = 1'b1;
                while (expected_words.size() != 0 || in_valid)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        $display("ran %0d bars over %0d period settings with series restarts",
                 words_seen, 6);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
